[hdl/orbb_pkg.sv]
// ----------------------------------------------------------------------------
// orbb_pkg: shared types for the overwriting byte ring buffer
// Field widths, storage depth, the input mode code, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package orbb_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 7;
	// storage bytes; fill and capacity fields are COUNT_W bits wide
	localparam int unsigned DEPTH   = 64;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHOW
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic push;   // store the input byte
		logic pop;    // load the run counter, take the run off the fill
		logic rd;     // read the oldest byte, advance the read position
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic run_zero;     // capped count of the waiting pop is zero
		logic remain_zero;  // no byte of the run is left to read
	} status_t;

endpackage

`default_nettype wire

[hdl/orbb_ctrl.sv]
// ----------------------------------------------------------------------------
// orbb_ctrl: sequencer of the ring buffer
// Accept words while idle, then step a pop run through read and show states.
// ----------------------------------------------------------------------------
`default_nettype none

module orbb_ctrl
	import orbb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_mode,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode_t'(in_mode) == MODE_PUSH) begin
						cmd.push = 1'b1;
					end else if (!status.run_zero) begin
						cmd.pop = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					// fetch the next byte as the current one leaves
					if (status.remain_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hdl/orbb_dpath.sv]
// ----------------------------------------------------------------------------
// orbb_dpath: storage and positions of the ring buffer
// Byte memory, read and write positions, fill count, capacity and run counter.
// ----------------------------------------------------------------------------
`default_nettype none

module orbb_dpath
	import orbb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_data,
	input  wire logic [BYTE_W-1:0]  push_byte,
	input  wire logic [COUNT_W-1:0] pop_count,
	output logic      [BYTE_W-1:0]  out_byte,
	output logic                    last_of_run,
	output logic      [COUNT_W-1:0] fill_after
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
	localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

	logic [BYTE_W-1:0]  mem [DEPTH];
	logic [BYTE_W-1:0]  rd_data_q;
	logic [AW-1:0]      rd_pos_q;
	logic [AW-1:0]      wr_pos_q;
	logic [COUNT_W-1:0] fill_q;
	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] remain_q;
	logic [COUNT_W-1:0] run;
	logic [COUNT_W-1:0] cap_d;

	// step a position, wrap at the capacity in use
	function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
	                                          input logic [COUNT_W-1:0] cap);
		logic [AW:0] nxt;
		nxt = {1'b0, pos} + {{AW{1'b0}}, 1'b1};
		if (CW'(nxt) >= CW'(cap)) begin
			return '0;
		end
		return nxt[AW-1:0];
	endfunction

	assign run = (pop_count > fill_q) ? fill_q : pop_count;

	always_comb begin
		if (cfg_data == '0) begin
			cap_d = COUNT_W'(1);
		end else if (CW'(cfg_data) > DEPTH_CW) begin
			cap_d = DEPTH_CW[COUNT_W-1:0];
		end else begin
			cap_d = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			fill_q   <= '0;
			remain_q <= '0;
			cap_q    <= DEPTH_CW[COUNT_W-1:0];
		end else if (cfg_we) begin
			cap_q    <= cap_d;
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			fill_q   <= '0;
		end else begin
			if (cmd.push) begin
				wr_pos_q <= advance(wr_pos_q, cap_q);
				if (fill_q < cap_q) begin
					fill_q <= fill_q + COUNT_W'(1);
				end else begin
					// full: drop the oldest byte
					rd_pos_q <= advance(rd_pos_q, cap_q);
				end
			end
			if (cmd.pop) begin
				fill_q   <= fill_q - run;
				remain_q <= run;
			end
			if (cmd.rd) begin
				rd_pos_q <= advance(rd_pos_q, cap_q);
				remain_q <= remain_q - COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !cfg_we) begin
			mem[wr_pos_q] <= push_byte;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_pos_q];
		end
	end

	assign status.run_zero    = (run == '0);
	assign status.remain_zero = (remain_q == '0);

	assign out_byte    = rd_data_q;
	assign last_of_run = (remain_q == '0);
	assign fill_after  = fill_q;

endmodule

`default_nettype wire

[hdl/overwriting_byte_ring_buffer.sv]
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer: byte ring buffer that overwrites the oldest
// Circular byte store with a configurable capacity and run-based pops.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_*. tuser selects the kind: 0 pushes the byte in
//   tdata[7:0], 1 pops up to tdata[14:8] bytes. A push into a full buffer
//   overwrites the oldest byte. A pop is capped to the current fill; a pop
//   capped to zero yields nothing.
//   Each popped byte leaves on m_* as one word, oldest first: tdata[7:0] the
//   byte, tdata[14:8] the fill left after the whole pop, tlast on the final
//   byte of the run.
//   The cfg channel sets the capacity (0 reads as 1, above DEPTH as DEPTH)
//   and empties the buffer; write it only while the block is idle.
// Timing:
//   A push or an empty pop is taken in the idle state, which stays ready for
//   the next word. A pop of N bytes goes to the read state, where the memory
//   read is registered, then to the show state with its first byte; then one
//   byte per cycle while m_tready stays high. The next input word is taken
//   the cycle after the last byte leaves.
//   One memory read port sets the one-byte-per-cycle output rate while m_tready is high.
// Reset and stall:
//   arst_n empties the buffer and sets the capacity to DEPTH; stored bytes
//   are not cleared. A low m_tready holds the shown word and stops reads.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_byte_ring_buffer
	import orbb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration: capacity
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data,
	// input words
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [15:0]        s_tdata,   // [7:0] push_byte, [14:8] pop_count, [15] zero
	input  wire logic               s_tuser,   // [0] mode
	// output words
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,   // [7:0] out_byte, [14:8] fill_after, [15] zero
	output logic                    m_tlast    // last_of_run
);

	cmd_t               cmd;
	status_t            status;
	logic [BYTE_W-1:0]  out_byte;
	logic [COUNT_W-1:0] fill_after;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	orbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	orbb_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_valid),
		.cfg_data    (cfg_data),
		.push_byte   (s_tdata[7:0]),
		.pop_count   (s_tdata[14:8]),
		.out_byte    (out_byte),
		.last_of_run (m_tlast),
		.fill_after  (fill_after)
	);

	assign m_tdata = {1'b0, fill_after, out_byte};

endmodule

`default_nettype wire
